[rtl/greedy_coin_change_assert.svh]
// Assertion macros used by the RTL that checks itself.
`ifndef GREEDY_COIN_CHANGE_ASSERT_SVH
`define GREEDY_COIN_CHANGE_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define GCC_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("greedy_coin_change: invariant violated");

// When trig holds, cond must hold in the cycle after.
`define GCC_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("greedy_coin_change: sequence violated");

`endif

[rtl/gcc_pkg.sv]
package gcc_pkg;

    localparam int VALUE_W = 32;
    localparam int DENOM_W = 16;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int STEP_W  = 5;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
    localparam logic [OP_W-1:0] OP_CHANGE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

    // Last step of the bit-serial divider (one quotient bit per step).
    localparam logic [STEP_W-1:0] DIV_LAST_STEP = 5'd31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_CH_RD,
        ST_CH_LD,
        ST_CH_DIV,
        ST_CH_ACC,
        ST_EMIT
    } state_t;

endpackage

[rtl/greedy_coin_change.sv]
// Greedy coin change over a sorted table of coin denominations.
// Input channel s_axis: tuser carries the opcode (clear, load, change) and
// tdata the 32-bit value. Output channel m_axis: tdata carries denomination,
// coin count, remainder and running total; tuser the status; tlast marks
// the final result of an item.
// A load inserts its denomination at the sorted place in a descending table
// held in a RAM; every entry that moves down passes through a read state,
// then a compare-and-write state.
// A change walks the table largest first and gives one result per entry.
// Each entry passes through read, load, the bit-serial divider that retires
// one quotient bit per cycle, accumulate and hand-off.
// Clear, rejected loads and a change on an empty table go straight to hand-off.
// One item is worked at a time; the next is taken once the last result of
// the current one sits in the output register.
// Reset empties the table at once; no clearing pass is needed.
// When the receiver stalls, the finished result holds in the output register
// and the engine waits before handing over the next one.
`include "greedy_coin_change_assert.svh"

module greedy_coin_change #(
    parameter int MAX_COINS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] value
    input  logic [1:0]   s_axis_tuser,   // [1:0] op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,   // [15:0] denomination, [47:16] coin_count,
                                         // [79:48] remainder, [111:80] total_coins
    output logic [1:0]   m_axis_tuser,   // [1:0] status
    output logic         m_axis_tlast
);

    localparam int ADDR_W = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
    localparam int CNT_W  = $clog2(MAX_COINS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_COINS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    gcc_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              ptr_reg;
    logic [gcc_pkg::DENOM_W-1:0]   den_reg;
    logic [gcc_pkg::VALUE_W-1:0]   dvd_reg;
    logic [gcc_pkg::DENOM_W-1:0]   part_reg;
    logic [gcc_pkg::STEP_W-1:0]    step_reg;

    logic [gcc_pkg::DENOM_W-1:0]   res_den_reg;
    logic [gcc_pkg::VALUE_W-1:0]   res_cnt_reg;
    logic [gcc_pkg::VALUE_W-1:0]   res_rem_reg;
    logic [gcc_pkg::VALUE_W-1:0]   res_tot_reg;
    logic [gcc_pkg::STAT_W-1:0]    res_sta_reg;
    logic                          res_last_reg;

    logic                          m_valid_reg;
    logic [111:0]                  m_data_reg;
    logic [gcc_pkg::STAT_W-1:0]    m_user_reg;
    logic                          m_last_reg;

    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic [gcc_pkg::DENOM_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]             ram_raddr;
    logic [gcc_pkg::DENOM_W-1:0]   ram_rdata;

    logic                          in_xfer;
    logic                          out_free;
    logic                          out_load;
    logic                          load_bad;
    logic                          table_full;
    logic                          table_empty;
    logic                          shift_down;
    logic [CNT_W-1:0]              ptr_m1;
    logic [gcc_pkg::DENOM_W:0]     trial;
    logic [gcc_pkg::DENOM_W:0]     diff;
    logic                          trial_ge;
    logic [gcc_pkg::VALUE_W-1:0]   tot_sum;

    gcc_ram #(
        .WIDTH (gcc_pkg::DENOM_W),
        .DEPTH (MAX_COINS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_xfer     = s_axis_tvalid && s_axis_tready;
    assign out_free    = !m_valid_reg || m_axis_tready;
    assign load_bad    = (s_axis_tdata == '0) || (s_axis_tdata[31:16] != '0);
    assign table_full  = (count_reg >= MAX_CNT);
    assign table_empty = (count_reg == '0);
    assign ptr_m1      = ptr_reg - CNT_ONE;
    assign shift_down  = (ram_rdata < den_reg);

    // One restoring-division step: bring down the next dividend bit.
    assign trial    = {part_reg, dvd_reg[gcc_pkg::VALUE_W-1]};
    assign trial_ge = (trial >= {1'b0, den_reg});
    assign diff     = trial - {1'b0, den_reg};
    assign tot_sum  = res_tot_reg + dvd_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gcc_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    case (s_axis_tuser)
                        gcc_pkg::OP_CLEAR:  state_next = gcc_pkg::ST_EMIT;
                        gcc_pkg::OP_LOAD:   state_next = (load_bad || table_full) ?
                                                         gcc_pkg::ST_EMIT :
                                                         gcc_pkg::ST_INS_RD;
                        gcc_pkg::OP_CHANGE: state_next = table_empty ?
                                                         gcc_pkg::ST_EMIT :
                                                         gcc_pkg::ST_CH_RD;
                        default:            state_next = gcc_pkg::ST_IDLE;
                    endcase
                end
            end
            gcc_pkg::ST_INS_RD:
                state_next = (ptr_reg == '0) ? gcc_pkg::ST_EMIT : gcc_pkg::ST_INS_CMP;
            gcc_pkg::ST_INS_CMP:
                state_next = shift_down ? gcc_pkg::ST_INS_RD : gcc_pkg::ST_EMIT;
            gcc_pkg::ST_CH_RD:
                state_next = gcc_pkg::ST_CH_LD;
            gcc_pkg::ST_CH_LD:
                state_next = gcc_pkg::ST_CH_DIV;
            gcc_pkg::ST_CH_DIV:
                if (step_reg == gcc_pkg::DIV_LAST_STEP)
                begin
                    state_next = gcc_pkg::ST_CH_ACC;
                end
            gcc_pkg::ST_CH_ACC:
                state_next = gcc_pkg::ST_EMIT;
            gcc_pkg::ST_EMIT:
                if (out_free)
                begin
                    state_next = res_last_reg ? gcc_pkg::ST_IDLE : gcc_pkg::ST_CH_RD;
                end
            default:
                state_next = gcc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = ptr_reg[ADDR_W-1:0];
        ram_wdata     = den_reg;
        ram_raddr     = ptr_reg[ADDR_W-1:0];
        out_load      = 1'b0;
        case (state_reg)
            gcc_pkg::ST_IDLE:
                s_axis_tready = 1'b1;
            gcc_pkg::ST_INS_RD:
            begin
                // At the top of the table: drop the new entry in directly.
                ram_we    = (ptr_reg == '0);
                ram_raddr = ptr_m1[ADDR_W-1:0];
            end
            gcc_pkg::ST_INS_CMP:
            begin
                ram_we    = 1'b1;
                ram_wdata = shift_down ? ram_rdata : den_reg;
            end
            gcc_pkg::ST_EMIT:
                out_load = out_free;
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= gcc_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (in_xfer && (s_axis_tuser == gcc_pkg::OP_CLEAR))
            begin
                count_reg <= '0;
            end
            else if (((state_reg == gcc_pkg::ST_INS_RD) && (ptr_reg == '0)) ||
                     ((state_reg == gcc_pkg::ST_INS_CMP) && !shift_down))
            begin
                count_reg <= count_reg + CNT_ONE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            gcc_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    den_reg      <= s_axis_tdata[gcc_pkg::DENOM_W-1:0];
                    res_den_reg  <= '0;
                    res_cnt_reg  <= '0;
                    res_rem_reg  <= '0;
                    res_tot_reg  <= '0;
                    res_sta_reg  <= gcc_pkg::STAT_OK;
                    res_last_reg <= 1'b1;
                    ptr_reg      <= '0;
                    case (s_axis_tuser)
                        gcc_pkg::OP_LOAD:
                        begin
                            ptr_reg <= count_reg;
                            if (load_bad)
                            begin
                                res_sta_reg <= gcc_pkg::STAT_BAD;
                            end
                            else if (table_full)
                            begin
                                res_sta_reg <= gcc_pkg::STAT_FULL;
                            end
                        end
                        gcc_pkg::OP_CHANGE:
                        begin
                            res_rem_reg <= s_axis_tdata;
                            if (table_empty)
                            begin
                                res_sta_reg <= gcc_pkg::STAT_EMPTY;
                            end
                        end
                        default:
                        begin
                            res_sta_reg <= gcc_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            gcc_pkg::ST_INS_RD:
            begin
                if (ptr_reg == '0)
                begin
                    res_den_reg <= den_reg;
                end
            end
            gcc_pkg::ST_INS_CMP:
            begin
                if (shift_down)
                begin
                    ptr_reg <= ptr_m1;
                end
                else
                begin
                    res_den_reg <= den_reg;
                end
            end
            gcc_pkg::ST_CH_LD:
            begin
                den_reg  <= ram_rdata;
                dvd_reg  <= res_rem_reg;
                part_reg <= '0;
                step_reg <= '0;
            end
            gcc_pkg::ST_CH_DIV:
            begin
                part_reg <= trial_ge ? diff[gcc_pkg::DENOM_W-1:0] :
                                       trial[gcc_pkg::DENOM_W-1:0];
                dvd_reg  <= {dvd_reg[gcc_pkg::VALUE_W-2:0], trial_ge};
                step_reg <= step_reg + 5'd1;
            end
            gcc_pkg::ST_CH_ACC:
            begin
                res_den_reg  <= den_reg;
                res_cnt_reg  <= dvd_reg;
                res_rem_reg  <= {{(gcc_pkg::VALUE_W - gcc_pkg::DENOM_W){1'b0}}, part_reg};
                res_tot_reg  <= tot_sum;
                res_last_reg <= ((ptr_reg + CNT_ONE) == count_reg);
                ptr_reg      <= ptr_reg + CNT_ONE;
            end
            default:
            begin
                step_reg <= step_reg;
            end
        endcase
        if (out_load)
        begin
            m_data_reg <= {res_tot_reg, res_rem_reg, res_cnt_reg, res_den_reg};
            m_user_reg <= res_sta_reg;
            m_last_reg <= res_last_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

    `GCC_ASSERT_ALWAYS(a_count_in_range, count_reg <= MAX_CNT)
    `GCC_ASSERT_ALWAYS(a_div_partial_below_divisor,
                       (state_reg != gcc_pkg::ST_CH_DIV) || (part_reg < den_reg))
    `GCC_ASSERT_NEXT(a_last_result_frees_engine,
                     out_load && res_last_reg, state_reg == gcc_pkg::ST_IDLE)
    `GCC_ASSERT_NEXT(a_walk_stays_in_table,
                     state_reg == gcc_pkg::ST_CH_RD, ptr_reg < count_reg)

endmodule

[rtl/gcc_ram.sv]
module gcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[dv/greedy_coin_change_checker.sv]
`timescale 1ns / 1ps

module greedy_coin_change_checker #(
    parameter int MAX_COINS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] value
    input  logic [1:0]   s_axis_tuser,   // [1:0] op
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [111:0] m_axis_tdata,   // [15:0] denomination, [47:16] coin_count,
                                         // [79:48] remainder, [111:80] total_coins
    input  logic [1:0]   m_axis_tuser,   // [1:0] status
    input  logic         m_axis_tlast,
    output int unsigned  mismatches,
    output int unsigned  pending,
    output int unsigned  results_checked
);

    typedef struct packed {
        logic [gcc_pkg::DENOM_W-1:0] denomination;
        logic [gcc_pkg::VALUE_W-1:0] coin_count;
        logic [gcc_pkg::VALUE_W-1:0] remainder;
        logic [gcc_pkg::VALUE_W-1:0] total_coins;
        logic [gcc_pkg::STAT_W-1:0]  status;
        logic                        last;
    } coin_result_t;

    // Own copy of the denomination table, kept in descending order
    logic [gcc_pkg::DENOM_W-1:0] denoms [MAX_COINS];
    int                          n_denoms;
    coin_result_t                expected_coins_q [$];
    int unsigned                 n_bad;
    int unsigned                 n_seen;

    function automatic coin_result_t make_result(
        input logic [gcc_pkg::DENOM_W-1:0] den,
        input logic [gcc_pkg::VALUE_W-1:0] cnt,
        input logic [gcc_pkg::VALUE_W-1:0] rem,
        input logic [gcc_pkg::VALUE_W-1:0] tot,
        input logic [gcc_pkg::STAT_W-1:0]  st,
        input logic                        fin
    );
        coin_result_t r;
        r.denomination = den;
        r.coin_count   = cnt;
        r.remainder    = rem;
        r.total_coins  = tot;
        r.status       = st;
        r.last         = fin;
        return r;
    endfunction

    function automatic void predict_coin_item(input logic [gcc_pkg::OP_W-1:0] op,
                                              input logic [gcc_pkg::VALUE_W-1:0] amount);
        logic [gcc_pkg::VALUE_W-1:0] left;
        logic [gcc_pkg::VALUE_W-1:0] tally;
        logic [gcc_pkg::VALUE_W-1:0] cnt;
        logic [gcc_pkg::VALUE_W-1:0] d;
        int                          pos;
        int                          i;
        case (op)
            gcc_pkg::OP_CLEAR:
            begin
                n_denoms = 0;
                expected_coins_q.push_back(
                    make_result('0, '0, '0, '0, gcc_pkg::STAT_OK, 1'b1));
            end
            gcc_pkg::OP_LOAD:
            begin
                // zero/oversize check wins over the full check
                if (amount == '0 || amount > 32'h0000_FFFF)
                    expected_coins_q.push_back(
                        make_result('0, '0, '0, '0, gcc_pkg::STAT_BAD, 1'b1));
                else if (n_denoms >= MAX_COINS)
                    expected_coins_q.push_back(
                        make_result('0, '0, '0, '0, gcc_pkg::STAT_FULL, 1'b1));
                else
                begin
                    // equal values stay ahead of the new entry
                    pos = n_denoms;
                    while (pos > 0 && denoms[pos-1] < amount[gcc_pkg::DENOM_W-1:0])
                    begin
                        denoms[pos] = denoms[pos-1];
                        pos--;
                    end
                    denoms[pos] = amount[gcc_pkg::DENOM_W-1:0];
                    n_denoms++;
                    expected_coins_q.push_back(
                        make_result(amount[gcc_pkg::DENOM_W-1:0], '0, '0, '0,
                                    gcc_pkg::STAT_OK, 1'b1));
                end
            end
            gcc_pkg::OP_CHANGE:
            begin
                if (n_denoms == 0)
                    expected_coins_q.push_back(
                        make_result('0, '0, amount, '0, gcc_pkg::STAT_EMPTY, 1'b1));
                else
                begin
                    left  = amount;
                    tally = '0;
                    for (i = 0; i < n_denoms; i++)
                    begin
                        d   = {16'd0, denoms[i]};
                        cnt = '0;
                        if (d != '0)
                        begin
                            cnt  = left / d;
                            left = left % d;
                        end
                        tally += cnt;
                        expected_coins_q.push_back(make_result(denoms[i], cnt, left, tally,
                                                               gcc_pkg::STAT_OK,
                                                               i == n_denoms - 1));
                    end
                end
            end
            default: ;  // unused op code: no result, no state change
        endcase
    endfunction

    function automatic void compare_result(input coin_result_t got);
        coin_result_t want;
        n_seen++;
        if (expected_coins_q.size() == 0)
        begin
            if (n_bad < 10)
                $display("%0t: unexpected result den=%0d cnt=%0d rem=%0d tot=%0d st=%0d last=%0b",
                         $realtime, got.denomination, got.coin_count, got.remainder,
                         got.total_coins, got.status, got.last);
            n_bad++;
        end
        else
        begin
            want = expected_coins_q.pop_front();
            if (got.denomination !== want.denomination || got.coin_count !== want.coin_count ||
                got.remainder !== want.remainder || got.total_coins !== want.total_coins ||
                got.status !== want.status || got.last !== want.last)
            begin
                if (n_bad < 10)
                begin
                    $display("%0t: result %0d expected den=%0d cnt=%0d rem=%0d tot=%0d",
                             $realtime, n_seen, want.denomination, want.coin_count,
                             want.remainder, want.total_coins);
                    $display("    expected st=%0d last=%0b", want.status, want.last);
                    $display("%0t: result %0d got      den=%0d cnt=%0d rem=%0d tot=%0d",
                             $realtime, n_seen, got.denomination, got.coin_count,
                             got.remainder, got.total_coins);
                    $display("    got      st=%0d last=%0b", got.status, got.last);
                end
                n_bad++;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_denoms = 0;
            expected_coins_q.delete();
            n_bad  = 0;
            n_seen = 0;
        end
        else
        begin
            // results always belong to older items, so check before predicting
            if (m_axis_tvalid && m_axis_tready)
                compare_result(make_result(m_axis_tdata[15:0], m_axis_tdata[47:16],
                                           m_axis_tdata[79:48], m_axis_tdata[111:80],
                                           m_axis_tuser, m_axis_tlast));
            if (s_axis_tvalid && s_axis_tready)
                predict_coin_item(s_axis_tuser, s_axis_tdata);
        end
        mismatches      <= n_bad;
        pending         <= expected_coins_q.size();
        results_checked <= n_seen;
    end

endmodule

[dv/greedy_coin_change_tb.sv]
`timescale 1ns / 1ps

module greedy_coin_change_tb;

    localparam int                       MAX_COINS    = 16;
    localparam int                       RANDOM_ITEMS = 180;
    localparam int                       STALL_LIMIT  = 4000;
    localparam int                       DRAIN_CYCLES = 50;
    localparam logic [gcc_pkg::OP_W-1:0] OP_UNUSED    = 2'd3;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;   // [31:0] value
    logic [1:0]   s_axis_tuser;   // [1:0] op
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;   // [15:0] denomination, [47:16] coin_count,
                                  // [79:48] remainder, [111:80] total_coins
    logic [1:0]   m_axis_tuser;   // [1:0] status
    logic         m_axis_tlast;

    int unsigned  mismatches;
    int unsigned  pending;
    int unsigned  results_checked;

    logic         calm = 1'b0;
    int           idle_cycles = 0;
    int           n_clear = 0;
    int           n_load = 0;
    int           n_change = 0;
    int           n_ignored = 0;

    always #4 clk = ~clk;

    greedy_coin_change #(
        .MAX_COINS(MAX_COINS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    greedy_coin_change_checker #(
        .MAX_COINS(MAX_COINS)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .mismatches     (mismatches),
        .pending        (pending),
        .results_checked(results_checked)
    );

    // Receiver: stall at random except during the calm stretch
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 28);
    end

    // Abort when no transfer happens on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                         idle_cycles, pending);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_denom();
        case ($urandom_range(0, 3))
            0:       return 32'($urandom_range(1, 20));
            1:       return 32'($urandom_range(1, 1000));
            2:       return 32'd1;
            default: return 32'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic [31:0] pick_amount();
        case ($urandom_range(0, 2))
            0:       return 32'($urandom_range(0, 200));
            1:       return 32'($urandom_range(0, 100000));
            default: return $urandom;
        endcase
    endfunction

    task automatic push_item(input logic [gcc_pkg::OP_W-1:0] op, input logic [31:0] val);
        while (!calm && $urandom_range(0, 99) < 28)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= val;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        case (op)
            gcc_pkg::OP_CLEAR:  n_clear++;
            gcc_pkg::OP_LOAD:   n_load++;
            gcc_pkg::OP_CHANGE: n_change++;
            default:            n_ignored++;
        endcase
    endtask

    initial
    begin
        int directed_items;
        int sent;
        int k;
        int m;
        int i;
        logic [gcc_pkg::OP_W-1:0] op;

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = gcc_pkg::OP_CLEAR;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, rejected loads, duplicates, full table, clear
        push_item(gcc_pkg::OP_CHANGE, 32'hFFFF_FFFF);
        push_item(gcc_pkg::OP_LOAD, 32'd0);
        push_item(gcc_pkg::OP_LOAD, 32'h0001_0000);
        push_item(gcc_pkg::OP_LOAD, 32'd65535);
        push_item(gcc_pkg::OP_LOAD, 32'd1);
        push_item(gcc_pkg::OP_LOAD, 32'd5);
        push_item(gcc_pkg::OP_LOAD, 32'd5);
        push_item(gcc_pkg::OP_CHANGE, 32'hFFFF_FFFF);
        push_item(gcc_pkg::OP_CHANGE, 32'd0);
        push_item(OP_UNUSED, 32'hA5A5_5A5A);
        for (i = 0; i < MAX_COINS - 4; i++)
            push_item(gcc_pkg::OP_LOAD, 32'($urandom_range(1, 65535)));
        push_item(gcc_pkg::OP_LOAD, 32'd7);
        push_item(gcc_pkg::OP_LOAD, 32'd0);
        push_item(gcc_pkg::OP_CHANGE, 32'hFFFF_FFFF);
        push_item(gcc_pkg::OP_CLEAR, $urandom);
        push_item(gcc_pkg::OP_CHANGE, 32'd7);
        directed_items = n_clear + n_load + n_change;

        // Random: mostly clear/load/change sequences, some stray items
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            calm = (sent >= 90 && sent < 130);
            if ($urandom_range(0, 99) < 75)
            begin
                push_item(gcc_pkg::OP_CLEAR, $urandom);
                k = ($urandom_range(0, 3) == 0) ? $urandom_range(9, MAX_COINS)
                                                : $urandom_range(1, 6);
                for (i = 0; i < k; i++)
                    push_item(gcc_pkg::OP_LOAD, pick_denom());
                if (k == MAX_COINS && $urandom_range(0, 1) == 1)
                    push_item(gcc_pkg::OP_LOAD, pick_denom());
                m = $urandom_range(1, 4);
                for (i = 0; i < m; i++)
                    push_item(gcc_pkg::OP_CHANGE, pick_amount());
            end
            else
            begin
                op = gcc_pkg::OP_W'($urandom_range(0, 3));
                if (op == gcc_pkg::OP_LOAD)
                    case ($urandom_range(0, 2))
                        0:       push_item(op, 32'd0);
                        1:       push_item(op, $urandom | 32'h0001_0000);
                        default: push_item(op, pick_denom());
                    endcase
                else
                    push_item(op, (op == gcc_pkg::OP_CHANGE) ? pick_amount() : $urandom);
            end
            sent = n_clear + n_load + n_change - directed_items;
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        // let the checker register the last transfer before looking at the backlog
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d clears, %0d loads, %0d change requests, %0d unused-op items",
                 n_clear, n_load, n_change, n_ignored);
        $display("Compared %0d results field by field, %0d differed",
                 results_checked, mismatches);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
